@@ src/irpd_pkg.sv @@
// Shared types, codes and timing constants for the IR pulse-distance transmitter.
package irpd_pkg;

	localparam int STEP_W = 4;
	localparam int IDX_W  = 6;

	typedef logic [STEP_W-1:0] step_t;
	typedef logic [IDX_W-1:0]  idx_t;

	// protocol codes
	localparam logic [7:0] PROTO_LONG32  = 8'd2;
	localparam logic [7:0] PROTO_BURST12 = 8'd4;
	localparam logic [7:0] PROTO_BITS48  = 8'd7;
	localparam logic [7:0] PROTO_SHORT32 = 8'd8;

	// microprogram entry points and step addresses
	localparam step_t STEP_L32_HDR  = 4'd0;
	localparam step_t STEP_L32_BITS = 4'd1;
	localparam step_t STEP_L32_STOP = 4'd2;
	localparam step_t STEP_S32_HDR  = 4'd3;
	localparam step_t STEP_B48_HDR  = 4'd4;
	localparam step_t STEP_B48_BITS = 4'd5;
	localparam step_t STEP_B48_STOP = 4'd6;
	localparam step_t STEP_B12_HDR  = 4'd7;
	localparam step_t STEP_B12_BITS = 4'd8;
	localparam step_t STEP_B12_GAP  = 4'd9;

	// the 12-bit mode sends three bursts, counted 0..2
	localparam logic [1:0] BURST_LAST = 2'd2;

	// bit positions inside the 48-bit word {data_high, data_low}
	localparam idx_t IDX_TOP     = 6'd47;
	localparam idx_t IDX_HI_LSB  = 6'd16;
	localparam idx_t IDX_LO_LSB  = 6'd0;
	localparam idx_t IDX_B12_TOP = 6'd27;
	localparam idx_t IDX_B12_PEN = 6'd17;

	// timings in microseconds
	localparam logic [13:0] T_MARK_9000 = 14'd9000;
	localparam logic [13:0] T_MARK_4500 = 14'd4500;
	localparam logic [13:0] T_MARK_525  = 14'd525;
	localparam logic [13:0] T_MARK_2200 = 14'd2200;
	localparam logic [13:0] T_MARK_560  = 14'd560;
	localparam logic [13:0] T_MARK_1120 = 14'd1120;
	localparam logic [13:0] T_MARK_3380 = 14'd3380;
	localparam logic [13:0] T_MARK_420  = 14'd420;

	localparam logic [14:0] T_SPACE_4500  = 15'd4500;
	localparam logic [14:0] T_SPACE_525   = 15'd525;
	localparam logic [14:0] T_SPACE_1650  = 15'd1650;
	localparam logic [14:0] T_SPACE_500   = 15'd500;
	localparam logic [14:0] T_SPACE_24500 = 15'd24500;
	localparam logic [14:0] T_SPACE_1690  = 15'd1690;
	localparam logic [14:0] T_SPACE_420   = 15'd420;
	localparam logic [14:0] T_SPACE_1270  = 15'd1270;

	typedef enum logic [2:0] {
		SEQ_NEXT,
		SEQ_REPEAT,
		SEQ_JUMP,
		SEQ_BURST,
		SEQ_END
	} seq_t;

	// one control word of the microprogram
	typedef struct packed {
		logic [13:0] mark0;
		logic [13:0] mark1;
		logic [14:0] space0;
		logic [14:0] space1;
		logic        carrier;
		logic        load_idx;
		idx_t        idx;
		idx_t        stop_idx;
		seq_t        seq;
		step_t       target;
	} ucw_t;

	// sequencer to datapath
	typedef struct packed {
		logic        emit;
		logic [13:0] mark0;
		logic [13:0] mark1;
		logic [14:0] space0;
		logic [14:0] space1;
		logic        carrier;
		logic        last;
		idx_t        idx;
	} pulse_ctrl_t;

	typedef struct packed {
		logic [7:0]  protocol;
		logic [31:0] data_high;
		logic [15:0] data_low;
	} req_t;

	typedef struct packed {
		logic [13:0] mark_us;
		logic [14:0] space_us;
		logic        carrier_select;
		logic        last;
	} pulse_t;

endpackage

@@ src/irpd_ucode_rom.sv @@
// Microprogram ROM: one control word per step address.
module irpd_ucode_rom (
	input  irpd_pkg::step_t addr,
	output irpd_pkg::ucw_t  cw
);

	function automatic irpd_pkg::ucw_t mk(
		input logic [13:0]     m0,
		input logic [13:0]     m1,
		input logic [14:0]     s0,
		input logic [14:0]     s1,
		input logic            car,
		input logic            ld,
		input irpd_pkg::idx_t  idx,
		input irpd_pkg::idx_t  stop,
		input irpd_pkg::seq_t  seq,
		input irpd_pkg::step_t tgt
	);
		irpd_pkg::ucw_t w;
		w.mark0    = m0;
		w.mark1    = m1;
		w.space0   = s0;
		w.space1   = s1;
		w.carrier  = car;
		w.load_idx = ld;
		w.idx      = idx;
		w.stop_idx = stop;
		w.seq      = seq;
		w.target   = tgt;
		return w;
	endfunction

	always_comb begin
		case (addr)
			irpd_pkg::STEP_L32_HDR: cw = mk(irpd_pkg::T_MARK_9000, irpd_pkg::T_MARK_9000,
				irpd_pkg::T_SPACE_4500, irpd_pkg::T_SPACE_4500, 1'b0, 1'b1,
				irpd_pkg::IDX_TOP, irpd_pkg::IDX_LO_LSB, irpd_pkg::SEQ_NEXT,
				irpd_pkg::STEP_L32_HDR);
			irpd_pkg::STEP_L32_BITS: cw = mk(irpd_pkg::T_MARK_525, irpd_pkg::T_MARK_525,
				irpd_pkg::T_SPACE_525, irpd_pkg::T_SPACE_1650, 1'b0, 1'b0,
				irpd_pkg::IDX_TOP, irpd_pkg::IDX_HI_LSB, irpd_pkg::SEQ_REPEAT,
				irpd_pkg::STEP_L32_HDR);
			irpd_pkg::STEP_L32_STOP: cw = mk(irpd_pkg::T_MARK_525, irpd_pkg::T_MARK_525,
				irpd_pkg::T_SPACE_1650, irpd_pkg::T_SPACE_1650, 1'b0, 1'b0,
				irpd_pkg::IDX_TOP, irpd_pkg::IDX_LO_LSB, irpd_pkg::SEQ_END,
				irpd_pkg::STEP_L32_HDR);
			irpd_pkg::STEP_S32_HDR: cw = mk(irpd_pkg::T_MARK_4500, irpd_pkg::T_MARK_4500,
				irpd_pkg::T_SPACE_4500, irpd_pkg::T_SPACE_4500, 1'b0, 1'b1,
				irpd_pkg::IDX_TOP, irpd_pkg::IDX_LO_LSB, irpd_pkg::SEQ_JUMP,
				irpd_pkg::STEP_L32_BITS);
			irpd_pkg::STEP_B48_HDR: cw = mk(irpd_pkg::T_MARK_3380, irpd_pkg::T_MARK_3380,
				irpd_pkg::T_SPACE_1690, irpd_pkg::T_SPACE_1690, 1'b0, 1'b1,
				irpd_pkg::IDX_TOP, irpd_pkg::IDX_LO_LSB, irpd_pkg::SEQ_NEXT,
				irpd_pkg::STEP_L32_HDR);
			irpd_pkg::STEP_B48_BITS: cw = mk(irpd_pkg::T_MARK_420, irpd_pkg::T_MARK_420,
				irpd_pkg::T_SPACE_420, irpd_pkg::T_SPACE_1270, 1'b0, 1'b0,
				irpd_pkg::IDX_TOP, irpd_pkg::IDX_LO_LSB, irpd_pkg::SEQ_REPEAT,
				irpd_pkg::STEP_L32_HDR);
			irpd_pkg::STEP_B48_STOP: cw = mk(irpd_pkg::T_MARK_420, irpd_pkg::T_MARK_420,
				irpd_pkg::T_SPACE_420, irpd_pkg::T_SPACE_420, 1'b0, 1'b0,
				irpd_pkg::IDX_TOP, irpd_pkg::IDX_LO_LSB, irpd_pkg::SEQ_END,
				irpd_pkg::STEP_L32_HDR);
			irpd_pkg::STEP_B12_HDR: cw = mk(irpd_pkg::T_MARK_2200, irpd_pkg::T_MARK_2200,
				irpd_pkg::T_SPACE_500, irpd_pkg::T_SPACE_500, 1'b1, 1'b1,
				irpd_pkg::IDX_B12_TOP, irpd_pkg::IDX_LO_LSB, irpd_pkg::SEQ_NEXT,
				irpd_pkg::STEP_L32_HDR);
			irpd_pkg::STEP_B12_BITS: cw = mk(irpd_pkg::T_MARK_560, irpd_pkg::T_MARK_1120,
				irpd_pkg::T_SPACE_500, irpd_pkg::T_SPACE_500, 1'b1, 1'b0,
				irpd_pkg::IDX_TOP, irpd_pkg::IDX_B12_PEN, irpd_pkg::SEQ_REPEAT,
				irpd_pkg::STEP_L32_HDR);
			// final bit of a burst carries the inter-burst gap
			irpd_pkg::STEP_B12_GAP: cw = mk(irpd_pkg::T_MARK_560, irpd_pkg::T_MARK_1120,
				irpd_pkg::T_SPACE_24500, irpd_pkg::T_SPACE_24500, 1'b1, 1'b0,
				irpd_pkg::IDX_TOP, irpd_pkg::IDX_LO_LSB, irpd_pkg::SEQ_BURST,
				irpd_pkg::STEP_B12_HDR);
			default: cw = mk(14'd0, 14'd0, 15'd0, 15'd0, 1'b0, 1'b0,
				irpd_pkg::IDX_TOP, irpd_pkg::IDX_LO_LSB, irpd_pkg::SEQ_END,
				irpd_pkg::STEP_L32_HDR);
		endcase
	end

endmodule

@@ src/irpd_sequencer.sv @@
// Step counter, bit index and burst counter that walk the microprogram.
module irpd_sequencer (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [7:0]           protocol,
	input  logic                 advance,
	input  irpd_pkg::ucw_t       cw,
	output irpd_pkg::step_t      step,
	output logic                 busy,
	output irpd_pkg::pulse_ctrl_t ctrl
);

	logic            busy_q;
	irpd_pkg::step_t step_q;
	irpd_pkg::idx_t  idx_q;
	logic [1:0]      burst_q;

	assign step = step_q;
	assign busy = busy_q;

	always_comb begin
		ctrl.emit    = busy_q;
		ctrl.mark0   = cw.mark0;
		ctrl.mark1   = cw.mark1;
		ctrl.space0  = cw.space0;
		ctrl.space1  = cw.space1;
		ctrl.carrier = cw.carrier;
		ctrl.idx     = idx_q;
		ctrl.last    = (cw.seq == irpd_pkg::SEQ_END) ||
			((cw.seq == irpd_pkg::SEQ_BURST) && (burst_q == irpd_pkg::BURST_LAST));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			step_q  <= irpd_pkg::STEP_L32_HDR;
			idx_q   <= irpd_pkg::IDX_TOP;
			burst_q <= 2'd0;
		end else if (start) begin
			burst_q <= 2'd0;
			case (protocol)
				irpd_pkg::PROTO_LONG32: begin
					busy_q <= 1'b1;
					step_q <= irpd_pkg::STEP_L32_HDR;
				end
				irpd_pkg::PROTO_SHORT32: begin
					busy_q <= 1'b1;
					step_q <= irpd_pkg::STEP_S32_HDR;
				end
				irpd_pkg::PROTO_BITS48: begin
					busy_q <= 1'b1;
					step_q <= irpd_pkg::STEP_B48_HDR;
				end
				irpd_pkg::PROTO_BURST12: begin
					busy_q <= 1'b1;
					step_q <= irpd_pkg::STEP_B12_HDR;
				end
				default: busy_q <= 1'b0; // unknown code: nothing to send
			endcase
		end else if (busy_q && advance) begin
			if (cw.load_idx) begin
				idx_q <= cw.idx;
			end
			case (cw.seq)
				irpd_pkg::SEQ_NEXT: step_q <= step_q + 1'b1;
				irpd_pkg::SEQ_REPEAT: begin
					idx_q <= idx_q - 1'b1;
					if (idx_q == cw.stop_idx) begin
						step_q <= step_q + 1'b1;
					end
				end
				irpd_pkg::SEQ_JUMP: step_q <= cw.target;
				irpd_pkg::SEQ_BURST: begin
					if (burst_q == irpd_pkg::BURST_LAST) begin
						busy_q <= 1'b0;
					end else begin
						burst_q <= burst_q + 1'b1;
						step_q  <= cw.target;
					end
				end
				default: busy_q <= 1'b0;
			endcase
		end
	end

endmodule

@@ src/irpd_datapath.sv @@
// Data word, bit select and the output register of the pulse channel.
module irpd_datapath (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  logic [31:0]           data_high,
	input  logic [15:0]           data_low,
	input  irpd_pkg::pulse_ctrl_t ctrl,
	input  logic                  pulse_ready,
	output logic                  pulse_valid,
	output irpd_pkg::pulse_t      pulse,
	output logic                  out_free
);

	logic [47:0]       data_q;
	logic              valid_q;
	irpd_pkg::pulse_t  pulse_q;
	logic              bit_val;

	assign bit_val     = data_q[ctrl.idx];
	assign out_free    = !valid_q || pulse_ready;
	assign pulse_valid = valid_q;
	assign pulse       = pulse_q;

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= {data_high, data_low};
		end
		if (ctrl.emit && out_free) begin
			pulse_q.mark_us        <= bit_val ? ctrl.mark1 : ctrl.mark0;
			pulse_q.space_us       <= bit_val ? ctrl.space1 : ctrl.space0;
			pulse_q.carrier_select <= ctrl.carrier;
			pulse_q.last           <= ctrl.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= ctrl.emit;
		end
	end

endmodule

@@ src/ir_remote_pulse_distance_transmitter.sv @@
// Top level: request port, microcode ROM, sequencer and pulse datapath.
// The sequencer registers a request before its first pulse enters the output register.
// Throughput: one pulse per cycle while pulse_ready is high, one microcode step each;
// a frame has 34, 39 or 50 pulses, and an unknown code is taken without sending any.
// The next request is taken while the final pulse of a frame still waits in the output register.
// Reset (arst_n low) clears the sequencer and empties the output register.
module ir_remote_pulse_distance_transmitter (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  irpd_pkg::req_t   req,
	output logic             pulse_valid,
	input  logic             pulse_ready,
	output irpd_pkg::pulse_t pulse
);

	irpd_pkg::step_t       step;
	irpd_pkg::ucw_t        cw;
	irpd_pkg::pulse_ctrl_t ctrl;
	logic                  busy;
	logic                  out_free;
	logic                  start;

	assign req_ready = !busy;
	assign start     = req_valid && req_ready;

	irpd_ucode_rom u_rom (
		.addr (step),
		.cw   (cw)
	);

	irpd_sequencer u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.protocol (req.protocol),
		.advance  (out_free),
		.cw       (cw),
		.step     (step),
		.busy     (busy),
		.ctrl     (ctrl)
	);

	irpd_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (start),
		.data_high   (req.data_high),
		.data_low    (req.data_low),
		.ctrl        (ctrl),
		.pulse_ready (pulse_ready),
		.pulse_valid (pulse_valid),
		.pulse       (pulse),
		.out_free    (out_free)
	);

endmodule

@@ src/irpd_checker.sv @@
// Port-level checks for the transmitter, bound to the top level.
module irpd_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             req_valid,
	input logic             req_ready,
	input irpd_pkg::req_t   req,
	input logic             pulse_valid,
	input logic             pulse_ready,
	input irpd_pkg::pulse_t pulse
);

	// a stalled pulse holds
	a_pulse_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pulse_valid && !pulse_ready |=> pulse_valid && $stable(pulse))
		else $error("stalled pulse changed or dropped");

	// a known protocol keeps the block busy after the transfer
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req.protocol == irpd_pkg::PROTO_LONG32 ||
		req.protocol == irpd_pkg::PROTO_BURST12 || req.protocol == irpd_pkg::PROTO_BITS48 ||
		req.protocol == irpd_pkg::PROTO_SHORT32) |=> !req_ready)
		else $error("request taken during a frame");

	a_pulse_range: assert property (@(posedge clk) disable iff (!arst_n)
		pulse_valid |-> pulse.mark_us >= 14'd420 && pulse.mark_us <= 14'd9000 &&
		pulse.space_us >= 15'd420 && pulse.space_us <= 15'd24500)
		else $error("pulse timing out of range");

	// the 40 kHz carrier is only used by the burst mode, whose spaces are fixed
	a_burst_space: assert property (@(posedge clk) disable iff (!arst_n)
		pulse_valid && pulse.carrier_select |->
		pulse.space_us == 15'd500 || pulse.space_us == 15'd24500)
		else $error("bad space on 40 kHz carrier");

endmodule

bind ir_remote_pulse_distance_transmitter irpd_checker u_irpd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req_valid),
	.req_ready   (req_ready),
	.req         (req),
	.pulse_valid (pulse_valid),
	.pulse_ready (pulse_ready),
	.pulse       (pulse)
);

@@ bench/tb_ir_remote_pulse_distance_transmitter.sv @@
// Self-checking testbench for the IR pulse-distance transmitter: directed frames, random traffic, stalls.
`timescale 1ns / 100ps

module tb_ir_remote_pulse_distance_transmitter;

	localparam int IDLE_PCT     = 21;
	localparam int WATCHDOG_MAX = 2000;
	localparam int HOLD_CYCLES  = 400;
	localparam int HOLD_AFTER   = 4000;
	localparam int RANDOM_ITEMS = 345;
	localparam int DRAIN_CYCLES = 16;

	// codes the block has no frame for
	localparam logic [7:0] UNKNOWN_CODES [7] = '{8'd0, 8'd1, 8'd3, 8'd5, 8'd6, 8'd9, 8'hFF};

	// expected pulse frames, filled per request and drained per pulse transfer
	class pulse_frame_checker;
		irpd_pkg::pulse_t expected_pulses[$];
		int               errors;
		int               pulses_checked;

		function void add_pulse(int unsigned mark, int unsigned space, bit carrier);
			irpd_pkg::pulse_t p;
			p.mark_us        = 14'(mark);
			p.space_us       = 15'(space);
			p.carrier_select = carrier;
			p.last           = 1'b0;
			expected_pulses.push_back(p);
		endfunction

		function void note_request(irpd_pkg::req_t r);
			int first;
			first = expected_pulses.size();
			case (r.protocol)
				irpd_pkg::PROTO_LONG32, irpd_pkg::PROTO_SHORT32: begin
					if (r.protocol == irpd_pkg::PROTO_LONG32)
						add_pulse(9000, 4500, 1'b0);
					else
						add_pulse(4500, 4500, 1'b0);
					for (int k = 31; k >= 0; k--)
						add_pulse(525, r.data_high[k] ? 1650 : 525, 1'b0);
					add_pulse(525, 1650, 1'b0);
				end
				irpd_pkg::PROTO_BURST12: begin
					for (int b = 0; b < 3; b++) begin
						add_pulse(2200, 500, 1'b1);
						// final bit of each burst carries the 24.5 ms inter-burst gap
						for (int k = 11; k >= 0; k--)
							add_pulse(r.data_high[k] ? 1120 : 560, (k == 0) ? 24500 : 500, 1'b1);
					end
				end
				irpd_pkg::PROTO_BITS48: begin
					add_pulse(3380, 1690, 1'b0);
					for (int k = 31; k >= 0; k--)
						add_pulse(420, r.data_high[k] ? 1270 : 420, 1'b0);
					for (int k = 15; k >= 0; k--)
						add_pulse(420, r.data_low[k] ? 1270 : 420, 1'b0);
					add_pulse(420, 420, 1'b0);
				end
				default: ;
			endcase
			if (expected_pulses.size() > first)
				expected_pulses[expected_pulses.size() - 1].last = 1'b1;
		endfunction

		function void check_pulse(irpd_pkg::pulse_t got);
			irpd_pkg::pulse_t want;
			pulses_checked++;
			if (expected_pulses.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t: unexpected pulse mark %0d space %0d carrier %0b last %0b",
						$realtime, got.mark_us, got.space_us, got.carrier_select, got.last);
				return;
			end
			want = expected_pulses.pop_front();
			if (got.mark_us !== want.mark_us || got.space_us !== want.space_us ||
			    got.carrier_select !== want.carrier_select || got.last !== want.last) begin
				errors++;
				if (errors <= 10)
					$display("%0t: pulse mismatch: expected %0d/%0d/%0b/%0b, got %0d/%0d/%0b/%0b",
						$realtime, want.mark_us, want.space_us, want.carrier_select, want.last,
						got.mark_us, got.space_us, got.carrier_select, got.last);
			end
		endfunction
	endclass

	logic             clk;
	logic             arst_n      = 1'b0;
	logic             req_valid   = 1'b0;
	logic             req_ready;
	irpd_pkg::req_t   req         = '0;
	logic             pulse_valid;
	logic             pulse_ready = 1'b0;
	irpd_pkg::pulse_t pulse;

	bit steady_flow = 1'b0;

	pulse_frame_checker sb = new();

	ir_remote_pulse_distance_transmitter DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req         (req),
		.pulse_valid (pulse_valid),
		.pulse_ready (pulse_ready),
		.pulse       (pulse)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// transfers seen at the edge, before any update from it
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && req_ready)
				sb.note_request(req);
			if (pulse_valid && pulse_ready)
				sb.check_pulse(pulse);
		end
	end

	// pulse sink: random stalls, always ready in the steady stretch, one long hold-off once the frames are flowing
	initial begin
		bit held;
		held = 1'b0;
		forever begin
			@(posedge clk);
			if (!held && sb.pulses_checked >= HOLD_AFTER) begin
				held = 1'b1;
				pulse_ready <= 1'b0;
				for (int n = 0; n < HOLD_CYCLES; n++)
					@(posedge clk);
			end else if (steady_flow) begin
				pulse_ready <= 1'b1;
			end else begin
				pulse_ready <= ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_MAX) begin
			@(posedge clk);
			if ((req_valid && req_ready) || (pulse_valid && pulse_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("watchdog: no transfer for %0d cycles", WATCHDOG_MAX);
		$display("** ir_remote_pulse_distance_transmitter: FAILED **");
		$finish;
	end

	function automatic irpd_pkg::req_t make_req(logic [7:0] code, logic [31:0] hi,
		logic [15:0] lo);
		irpd_pkg::req_t r;
		r.protocol  = code;
		r.data_high = hi;
		r.data_low  = lo;
		return r;
	endfunction

	function automatic irpd_pkg::req_t random_request();
		irpd_pkg::req_t r;
		int unsigned    pick;
		pick        = $urandom_range(99);
		r.data_high = $urandom();
		r.data_low  = 16'($urandom_range(16'hFFFF, 0));
		if (pick < 22)
			r.protocol = irpd_pkg::PROTO_LONG32;
		else if (pick < 44)
			r.protocol = irpd_pkg::PROTO_SHORT32;
		else if (pick < 64)
			r.protocol = irpd_pkg::PROTO_BURST12;
		else if (pick < 86)
			r.protocol = irpd_pkg::PROTO_BITS48;
		else
			r.protocol = 8'($urandom_range(255, 0));
		// flat payloads now and then
		pick = $urandom_range(99);
		if (pick < 4) begin
			r.data_high = '0;
			r.data_low  = '0;
		end else if (pick < 8) begin
			r.data_high = '1;
			r.data_low  = '1;
		end
		return r;
	endfunction

	task automatic offer_request(input irpd_pkg::req_t r);
		if (!steady_flow) begin
			while ($urandom_range(99) < IDLE_PCT) begin
				req_valid <= 1'b0;
				@(posedge clk);
			end
		end
		req       <= r;
		req_valid <= 1'b1;
		do
			@(posedge clk);
		while (!req_ready);
	endtask

	initial begin
		irpd_pkg::req_t r;
		int             sent;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		offer_request(make_req(irpd_pkg::PROTO_LONG32, 32'h0000_0000, 16'h0000));
		offer_request(make_req(irpd_pkg::PROTO_LONG32, 32'hFFFF_FFFF, 16'hFFFF));
		offer_request(make_req(irpd_pkg::PROTO_LONG32, 32'hA5C3_0F81, 16'h1234));
		offer_request(make_req(irpd_pkg::PROTO_SHORT32, 32'h0000_0000, 16'hFFFF));
		offer_request(make_req(irpd_pkg::PROTO_SHORT32, 32'hFFFF_FFFF, 16'h0000));
		offer_request(make_req(irpd_pkg::PROTO_SHORT32, 32'h8000_0001, 16'h5A5A));
		offer_request(make_req(irpd_pkg::PROTO_BURST12, 32'h0000_0000, 16'h0000));
		offer_request(make_req(irpd_pkg::PROTO_BURST12, 32'h0000_0FFF, 16'h0000));
		// upper bits and data_low must be ignored in the 12-bit mode
		offer_request(make_req(irpd_pkg::PROTO_BURST12, 32'hFFFF_F000, 16'hFFFF));
		offer_request(make_req(irpd_pkg::PROTO_BURST12, 32'h0000_0A5C, 16'h0F0F));
		offer_request(make_req(irpd_pkg::PROTO_BITS48, 32'h0000_0000, 16'h0000));
		offer_request(make_req(irpd_pkg::PROTO_BITS48, 32'hFFFF_FFFF, 16'hFFFF));
		offer_request(make_req(irpd_pkg::PROTO_BITS48, 32'h8000_0001, 16'h8001));
		offer_request(make_req(irpd_pkg::PROTO_BITS48, 32'h1234_5678, 16'hBEEF));
		foreach (UNKNOWN_CODES[i])
			offer_request(make_req(UNKNOWN_CODES[i], 32'hFFFF_FFFF, 16'hFFFF));
		offer_request(make_req(irpd_pkg::PROTO_LONG32, 32'h0F0F_F0F0, 16'h0000));

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			// a stretch with neither side idling
			steady_flow = (sent >= 200 && sent < 260);
			r = random_request();
			offer_request(r);
			sent++;
		end
		steady_flow = 1'b0;
		req_valid <= 1'b0;

		// let the monitor note the final transfer first
		@(posedge clk);
		while (sb.expected_pulses.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.errors == 0)
			$display("** ir_remote_pulse_distance_transmitter: PASSED **");
		else
			$display("** ir_remote_pulse_distance_transmitter: FAILED **");
		$finish;
	end

endmodule
